### design/pvsd_pkg.sv
// package: payload structs, status codes, register indexes and decode constants
`timescale 1ns / 1ps

package pvsd_pkg;

	localparam int unsigned ValueW    = 64;
	localparam int unsigned PosW      = 4;
	localparam int unsigned GroupBits = 7;
	localparam int unsigned MaxBytes  = 10;
	localparam int unsigned CfgIdxW   = 2;

	localparam logic [7:0] GROUP_MASK = 8'h7F;
	localparam logic [7:0] CONT_BIT   = 8'h80;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_SIGNED_MODE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_DELTA_MODE  = 2'd1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERLONG  = 2'd1,
		STATUS_TRUNCATED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       field_end;
	} in_item_t;

	typedef struct packed {
		logic [ValueW-1:0] value;
		status_t           status;
		logic              last_in_field;
	} out_item_t;

	typedef struct packed {
		logic               we;
		logic [CfgIdxW-1:0] index;
		logic               data;
	} cfg_write_t;

endpackage

### design/pvsd_decode.sv
// module: varint accumulate, zigzag, delta sum and field state for one byte
`timescale 1ns / 1ps

module pvsd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pvsd_pkg::cfg_write_t cfg,
	input  pvsd_pkg::in_item_t   item,
	input  logic                 advance,
	output logic                 res_valid,
	output pvsd_pkg::out_item_t  res
);

	logic                          signed_mode_q;
	logic                          delta_mode_q;
	logic [pvsd_pkg::ValueW-1:0]   partial_q;
	logic [pvsd_pkg::PosW-1:0]     pos_q;
	logic [pvsd_pkg::ValueW-1:0]   sum_q;
	logic                          disc_q;

	logic [pvsd_pkg::ValueW-1:0]   partial_d;
	logic [pvsd_pkg::PosW-1:0]     pos_d;
	logic [pvsd_pkg::ValueW-1:0]   sum_d;
	logic                          disc_d;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
			delta_mode_q  <= 1'b0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				pvsd_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg.data;
				pvsd_pkg::CFG_DELTA_MODE:  delta_mode_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [6:0]                  shift_amt;
		logic [pvsd_pkg::ValueW-1:0] grp_ext;
		logic [pvsd_pkg::ValueW-1:0] acc;
		logic [pvsd_pkg::ValueW-1:0] zz;
		logic [pvsd_pkg::ValueW-1:0] sum_new;

		shift_amt = 7'(pos_q) * 7'(pvsd_pkg::GroupBits);
		grp_ext   = {56'b0, item.data_byte & pvsd_pkg::GROUP_MASK};
		acc       = partial_q | (grp_ext << shift_amt[5:0]);
		zz        = signed_mode_q ? ((acc >> 1) ^ {pvsd_pkg::ValueW{acc[0]}}) : acc;
		sum_new   = sum_q + zz;

		partial_d         = partial_q;
		pos_d             = pos_q;
		sum_d             = sum_q;
		disc_d            = disc_q;
		res_valid         = 1'b0;
		res.value         = '0;
		res.status        = pvsd_pkg::STATUS_OK;
		res.last_in_field = item.field_end;

		priority if (disc_q) begin
			// dropping the rest of a bad field
		end else if (pos_q >= pvsd_pkg::PosW'(pvsd_pkg::MaxBytes)) begin
			res_valid  = 1'b1;
			res.status = pvsd_pkg::STATUS_OVERLONG;
		end else if ((item.data_byte & pvsd_pkg::CONT_BIT) != 8'h00) begin
			partial_d = acc;
			pos_d     = pos_q + pvsd_pkg::PosW'(1);
			if (item.field_end) begin
				res_valid  = 1'b1;
				res.status = pvsd_pkg::STATUS_TRUNCATED;
			end
		end else begin
			res_valid = 1'b1;
			partial_d = '0;
			pos_d     = '0;
			if (delta_mode_q) begin
				sum_d     = sum_new;
				res.value = sum_new;
			end else begin
				res.value = zz;
			end
		end

		// field end clears all field state, an error mid-field starts discarding
		if (item.field_end) begin
			partial_d = '0;
			pos_d     = '0;
			sum_d     = '0;
			disc_d    = 1'b0;
		end else if (res_valid && res.status != pvsd_pkg::STATUS_OK) begin
			disc_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			disc_q    <= 1'b0;
		end else if (advance) begin
			partial_q <= partial_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			disc_q    <= disc_d;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pvsd_pkg::PosW'(pvsd_pkg::MaxBytes))
		else $error("byte position beyond ten");

	a_field_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.field_end |=> pos_q == '0 && sum_q == '0 && !disc_q)
		else $error("field state not cleared after field end");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != pvsd_pkg::STATUS_OK |-> res.value == '0)
		else $error("error result carries a value");

	a_disc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> !res_valid)
		else $error("result while discarding");

endmodule

### design/packed_varint_stream_decoder_top.sv
// top level: input register, byte decode and result register of the varint decoder
`timescale 1ns / 1ps
//
// channel  direction  handshake            payload
// in       in         in_valid/in_ready    in_data   (data_byte, field_end)
// out      out        out_valid/out_ready  out_data  (value, status, last_in_field)
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte per cycle sustained while out does not stall; a byte's result shows on out from the result register
// the input register feeds the decode logic, which updates field state and
// loads the result register in the same cycle the byte moves on
// reset clears mode registers, field state and both valid flags
// when out stalls, one more byte is taken into the input register; in_ready
// then follows out_ready combinationally, bytes giving no result always drain

module packed_varint_stream_decoder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pvsd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pvsd_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pvsd_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic                                cfg_data
);

	// input register
	logic                s1_valid_q;
	pvsd_pkg::in_item_t  s1_item_s1;

	// result register
	logic                out_valid_q;
	pvsd_pkg::out_item_t out_item_q;

	logic                res_valid;
	pvsd_pkg::out_item_t res;
	logic                s1_advance;
	pvsd_pkg::cfg_write_t cfg;

	// config transactions are always taken
	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// byte moves on when it gives no result or its result has somewhere to go
	assign s1_advance = s1_valid_q && (!res_valid || !out_valid_q || out_ready);
	assign in_ready   = !s1_valid_q || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_item_s1 <= in_data;
		end
	end

	pvsd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (s1_item_s1),
		.advance   (s1_advance),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register, reloaded in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && res_valid) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

### bench/packed_varint_stream_decoder_top_test.sv
// testbench: packed varint decoder checked against a cycle-free decode model, random handshakes
`timescale 1ns / 1ps

module packed_varint_stream_decoder_top_test;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned SettleCycles = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pvsd_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pvsd_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pvsd_pkg::CfgIdxW-1:0] cfg_index = pvsd_pkg::CFG_SIGNED_MODE;
	logic cfg_data = 1'b0;

	packed_varint_stream_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decode model state, mirrors the block after reset
	logic [pvsd_pkg::ValueW-1:0] acc_groups = '0;
	int unsigned                 group_count = 0;
	logic [pvsd_pkg::ValueW-1:0] field_sum = '0;
	bit                          dropping_field = 1'b0;
	bit                          zigzag_on = 1'b0;
	bit                          delta_on = 1'b0;

	// results the model says are still owed by the block, oldest first
	pvsd_pkg::out_item_t results_due[$];

	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;

	// idle shaping: each side draws a wait of 0..max per transaction
	int unsigned in_gap_max = 0;
	int unsigned out_gap_max = 0;
	// one-shot long receiver hold-off, picked up by the receiver process
	int unsigned out_hold_request = 0;

	task automatic clear_field_state();
		acc_groups = '0;
		group_count = 0;
		field_sum = '0;
		dropping_field = 1'b0;
	endtask

	// advance the model by one accepted byte, queue the result it causes if any
	task automatic predict_varint_byte(input pvsd_pkg::in_item_t it);
		pvsd_pkg::out_item_t r;
		logic [pvsd_pkg::ValueW-1:0] v;
		r.value = '0;
		r.status = pvsd_pkg::STATUS_OK;
		r.last_in_field = it.field_end;
		if (dropping_field) begin
			// rest of a broken field is swallowed, its end still clears state
			if (it.field_end)
				clear_field_state();
			return;
		end
		if (group_count >= pvsd_pkg::MaxBytes) begin
			r.status = pvsd_pkg::STATUS_OVERLONG;
		end else begin
			// tenth group sits at bit 63, the shift drops its upper bits
			acc_groups |= pvsd_pkg::ValueW'(it.data_byte & pvsd_pkg::GROUP_MASK)
				<< (group_count * pvsd_pkg::GroupBits);
			group_count++;
			if ((it.data_byte & pvsd_pkg::CONT_BIT) != 0) begin
				if (!it.field_end)
					return;
				r.status = pvsd_pkg::STATUS_TRUNCATED;
			end else begin
				v = acc_groups;
				if (zigzag_on)
					v = (v >> 1) ^ {pvsd_pkg::ValueW{v[0]}};
				if (delta_on) begin
					field_sum += v;
					v = field_sum;
				end
				r.value = v;
				acc_groups = '0;
				group_count = 0;
			end
		end
		results_due.push_back(r);
		if (it.field_end)
			clear_field_state();
		else if (r.status != pvsd_pkg::STATUS_OK)
			dropping_field = 1'b1;
	endtask

	// one input transaction; valid stays up from the previous byte when no gap is drawn
	task automatic send_byte(input logic [7:0] b, input bit last);
		pvsd_pkg::in_item_t it;
		int unsigned gap;
		it.data_byte = b;
		it.field_end = last;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_varint_byte(it);
		bytes_sent++;
	endtask

	// minimal little-endian base-128 encoding of one value
	task automatic send_varint(input logic [pvsd_pkg::ValueW-1:0] v, input bit last);
		logic [7:0] b;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> pvsd_pkg::GroupBits;
			b[7] = (v != 0);
			send_byte(b, last && (v == 0));
		end while (v != 0);
	endtask

	// drop valid, wait for every owed result, then let the pipe empty out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// writes both mode registers back to back; only called with the block idle
	task automatic set_modes(input bit s, input bit d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= pvsd_pkg::CFG_SIGNED_MODE;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		zigzag_on = s;
		@(negedge clk);
		cfg_index <= pvsd_pkg::CFG_DELTA_MODE;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		delta_on = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [pvsd_pkg::ValueW-1:0] random_value();
		logic [pvsd_pkg::ValueW-1:0] v;
		v = {$urandom, $urandom};
		// skew toward short encodings, still reaching all ten bytes
		return v >> $urandom_range(0, pvsd_pkg::ValueW - 1);
	endfunction

	// one packed field: mostly clean varints, some raw, truncated, overlong or noise
	task automatic send_random_field();
		int unsigned count;
		int unsigned kind;
		int unsigned len;
		bit last;
		bit ended;
		logic [7:0] b;
		count = $urandom_range(1, 5);
		ended = 1'b0;
		for (int unsigned i = 0; i < count && !ended; i++) begin
			last = (i == count - 1);
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				send_varint(random_value(), last);
			end else if (kind < 15) begin
				// arbitrary groups, possibly non-minimal or with a junk tenth byte
				len = $urandom_range(1, pvsd_pkg::MaxBytes);
				for (int unsigned j = 0; j < len; j++) begin
					b = 8'($urandom_range(0, 255));
					b[7] = (j != len - 1);
					send_byte(b, last && (j == len - 1));
				end
			end else if (kind < 17) begin
				// field ends while the varint still wants more bytes
				len = $urandom_range(1, pvsd_pkg::MaxBytes);
				for (int unsigned j = 0; j < len; j++) begin
					b = 8'($urandom_range(0, 255));
					b[7] = 1'b1;
					send_byte(b, j == len - 1);
				end
				ended = 1'b1;
			end else if (kind < 19) begin
				// ten continuation bytes, the eleventh is the overlong one
				for (int unsigned j = 0; j < pvsd_pkg::MaxBytes; j++) begin
					b = 8'($urandom_range(0, 255));
					b[7] = 1'b1;
					send_byte(b, 1'b0);
				end
				send_byte(8'($urandom_range(0, 255)), last);
			end else begin
				b = 8'($urandom_range(0, 255));
				ended = ($urandom_range(0, 1) == 1);
				send_byte(b, ended || last);
			end
		end
	endtask

	// smallest and largest values, tenth byte high bits dropped
	task automatic test_unsigned_extremes();
		set_modes(1'b0, 1'b0);
		send_byte(8'h00, 1'b0);
		repeat (pvsd_pkg::MaxBytes - 1) send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		settle();
	endtask

	// zigzag of -1, +1, -2 summed inside one field, the sum wrapping through zero
	task automatic test_signed_delta();
		set_modes(1'b1, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		settle();
	endtask

	// field ending on a continuation byte, then overlong on the field's last byte
	task automatic test_malformed();
		set_modes(1'b0, 1'b1);
		send_byte(8'h80, 1'b1);
		repeat (pvsd_pkg::MaxBytes) send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
	endtask

	// mode switch between two varints of one field keeps the running sum
	task automatic test_mode_change_mid_field();
		set_modes(1'b0, 1'b1);
		send_byte(8'h05, 1'b0);
		settle();
		set_modes(1'b1, 1'b1);
		send_byte(8'h03, 1'b1);
		settle();
	endtask

	// receiver stalls for a long stretch while the sender keeps pushing
	task automatic test_backpressure();
		int unsigned stop_at;
		set_modes(1'b0, 1'b0);
		in_gap_max = 0;
		out_gap_max = 0;
		out_hold_request = 150;
		stop_at = bytes_sent + 40;
		while (bytes_sent < stop_at) send_random_field();
		settle();
	endtask

	// random fields under every mode setting and every idling mix
	task automatic test_random_fields();
		int unsigned stop_at;
		for (int unsigned phase = 0; phase < 8; phase++) begin
			set_modes(phase[0], phase[1]);
			in_gap_max = (phase % 3 == 0) ? 0 : 12;
			out_gap_max = (phase[2] == phase[0]) ? 12 : 0;
			stop_at = bytes_sent + 36;
			while (bytes_sent < stop_at) send_random_field();
			settle();
		end
	endtask

	// result side: random stalls per transaction, plus the one long hold-off
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			if (out_hold_request != 0) begin
				gap = out_hold_request;
				out_hold_request = 0;
			end else begin
				gap = $urandom_range(0, out_gap_max);
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// every result transaction is compared with the oldest owed result
	always @(posedge clk) begin
		pvsd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: expected none actual value %h status %0d last %0b",
					$time, out_data.value, out_data.status, out_data.last_in_field);
			end else begin
				want = results_due.pop_front();
				if (out_data.value !== want.value) begin
					mismatches++;
					$display("%0t value mismatch: expected %h actual %h",
						$time, want.value, out_data.value);
				end
				if (out_data.status !== want.status) begin
					mismatches++;
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, want.status, out_data.status);
				end
				if (out_data.last_in_field !== want.last_in_field) begin
					mismatches++;
					$display("%0t last_in_field mismatch: expected %0b actual %0b",
						$time, want.last_in_field, out_data.last_in_field);
				end
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("[packed_varint_stream_decoder_top] ERROR");
			$finish;
		end
	end

	initial begin
		// reset held, then released away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsigned_extremes();
		test_signed_delta();
		test_malformed();
		test_mode_change_mid_field();
		test_backpressure();
		test_random_fields();

		settle();
		if (mismatches == 0) begin
			$display("[packed_varint_stream_decoder_top] OK");
		end else begin
			$display("[packed_varint_stream_decoder_top] ERROR");
		end
		$finish;
	end

endmodule
